// ===== hw/rtl/stq_pkg.sv =====
// Shared types and constants of the software timer queue.
// No dependencies; every other file of the block refers to this package by scoped names.
package stq_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_FIRED   = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic CFG_TICK_RATE = 1'b0;
    localparam logic CFG_IDLE_SECS = 1'b1;

    localparam logic [31:0] TICK_RATE_RESET = 32'd62500000;
    localparam logic [7:0]  IDLE_SECS_RESET = 8'd5;

    typedef struct packed {
        logic [63:0] deadline;
        logic [15:0] tag;
        logic        expired;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stk_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_FULL,
        ST_MUL,
        ST_SUM,
        ST_ADD_SCAN,
        ST_ADD_ACK,
        ST_TICK_SCAN,
        ST_TICK_PUSH,
        ST_TICK_FILL,
        ST_TICK_SUM
    } state_t;

endpackage

// ===== hw/rtl/stq_ring_cell.sv =====
// One slot of the rotating timer ring.
// Depends on stq_pkg for the entry type.
module stq_ring_cell (
    input  logic            clk,
    input  logic            shift,
    input  stq_pkg::entry_t from_next,
    output stq_pkg::entry_t q
);

    stq_pkg::entry_t q_reg;
    stq_pkg::entry_t q_next;

    // The ring moves one place toward the head on every shift.
    always_comb
    begin
        q_next = shift ? from_next : q_reg;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ===== hw/rtl/stq_stack_cell.sv =====
// One slot of the last-in first-out chain that holds relocated survivors.
// Depends on stq_pkg for the entry and control types.
module stq_stack_cell (
    input  logic              clk,
    input  stq_pkg::stk_ctl_t ctl,
    input  stq_pkg::entry_t   from_above,
    input  stq_pkg::entry_t   from_below,
    output stq_pkg::entry_t   q
);

    stq_pkg::entry_t q_reg;
    stq_pkg::entry_t q_next;

    // A push moves everything one place down, a pop one place up.
    always_comb
    begin
        priority if (ctl.push)
        begin
            q_next = from_above;
        end
        else if (ctl.pop)
        begin
            q_next = from_below;
        end
        else
        begin
            q_next = q_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ===== hw/rtl/software_timer_queue.sv =====
// Top level of the software timer queue: control sequencer, timer ring and relocation stack.
// Depends on stq_pkg, stq_ring_cell and stq_stack_cell.
//
//  channel  | direction | signals                                | content
//  ---------+-----------+----------------------------------------+-------------------------------
//  request  | in        | s_tvalid s_tready s_tdata s_tuser      | add timer or tick
//  result   | out       | m_tvalid m_tready m_tdata m_tuser ...  | ack, fired tag or rearm summary
//  config   | in        | cfg_we cfg_index cfg_wdata             | tick_rate, idle_rearm_seconds
//
// An add request to a table that is not full passes through the accepting cycle, a multiply, a saturating
// add, a turn of the ring to compare against every live deadline, and the acknowledge.
// A tick request passes through the accepting cycle, a ring turn to report expirations and find the
// earliest survivor, a turn to push survivors that sit at or above the new count onto the stack,
// and a turn to drop them into the holes, then the summary.
// While the output register holds an earlier result that is not yet taken, a fired timer holds the
// ring at its slot, and the acknowledge and the summary wait.
// Reset empties the table at once; no clearing pass is needed.
// A new request is taken while the last result still waits in the output register.
module software_timer_queue (
    input  logic          clk,
    input  logic          rst_n,
    // request: now [63:0], delay_seconds [95:64], tag [111:96]
    input  logic [111:0]  s_tdata,
    // request: req_type [0]
    input  logic          s_tuser,
    input  logic          s_tvalid,
    output logic          s_tready,
    // result: fired_tag [15:0], queue_full [16], reload [17], interval [81:18], zero [87:82]
    output logic [87:0]   m_tdata,
    // result: kind [1:0]
    output logic [1:0]    m_tuser,
    output logic          m_tlast,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [31:0]   cfg_wdata
);

    localparam int N = stq_pkg::TIMER_SLOTS;

    // Configuration registers.
    logic [31:0] tick_rate_reg;
    logic [7:0]  idle_secs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_rate_reg <= stq_pkg::TICK_RATE_RESET;
            idle_secs_reg <= stq_pkg::IDLE_SECS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                stq_pkg::CFG_TICK_RATE: tick_rate_reg <= cfg_wdata;
                stq_pkg::CFG_IDLE_SECS: idle_secs_reg <= cfg_wdata[7:0];
                default:                tick_rate_reg <= tick_rate_reg;
            endcase
        end
    end

    // Control state.
    stq_pkg::state_t             state_reg, state_next;
    logic [stq_pkg::IDX_W-1:0]   pos_reg;
    logic [stq_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [stq_pkg::CNT_W-1:0]   surv_reg;
    logic                        earliest_reg;
    logic                        any_reg;
    logic [63:0]                 best_reg;

    // Request payload held for the whole operation.
    logic [63:0] now_reg;
    logic [31:0] delay_reg;
    logic [15:0] tag_reg;
    logic [63:0] prod_reg;
    logic [63:0] dl_reg;

    // Output register.
    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [15:0] out_tag_reg;
    logic        out_full_reg;
    logic        out_reload_reg;
    logic [63:0] out_interval_reg;
    logic        out_last_reg;

    // Ring and stack.
    stq_pkg::entry_t   ring_q [N];
    stq_pkg::entry_t   stk_q  [N];
    stq_pkg::entry_t   head;
    stq_pkg::entry_t   ring_in;
    stq_pkg::entry_t   new_entry;
    stq_pkg::entry_t   zero_entry;
    stq_pkg::stk_ctl_t stk_ctl;
    logic              ring_shift;

    // Sequencer outputs.
    logic        accept;
    logic        step;
    logic        pos_end;
    logic        emit;
    logic [1:0]  emit_kind;
    logic [15:0] emit_tag;
    logic        emit_full;
    logic        emit_reload;
    logic [63:0] emit_interval;
    logic        out_free;

    // Datapath helpers.
    logic [stq_pkg::CNT_W-1:0] pos_ext;
    logic                      in_tbl;
    logic                      head_expired;
    logic [63:0]               head_dist;
    logic [64:0]               dl_sum;
    logic [63:0]               prod_w;
    logic [39:0]               idle_w;

    assign head       = ring_q[0];
    assign pos_ext    = stq_pkg::CNT_W'(pos_reg);
    assign in_tbl     = pos_ext < count_reg;
    assign pos_end    = pos_reg == stq_pkg::IDX_W'(N - 1);
    assign out_free   = !out_valid_reg || m_tready;
    assign head_expired = in_tbl && (head.deadline <= now_reg);
    assign head_dist  = head.deadline - now_reg;
    assign prod_w     = 64'(delay_reg) * 64'(tick_rate_reg);
    assign dl_sum     = {1'b0, now_reg} + {1'b0, prod_reg};
    assign idle_w     = 40'(idle_secs_reg) * 40'(tick_rate_reg);
    assign zero_entry = '0;
    assign new_entry  = '{deadline: dl_reg, tag: tag_reg, expired: 1'b0};
    assign accept     = s_tvalid && s_tready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            stq_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == stq_pkg::REQ_TICK)
                    begin
                        state_next = stq_pkg::ST_TICK_SCAN;
                    end
                    else if (count_reg == stq_pkg::CNT_W'(N))
                    begin
                        state_next = stq_pkg::ST_ADD_FULL;
                    end
                    else
                    begin
                        state_next = stq_pkg::ST_MUL;
                    end
                end
            end
            stq_pkg::ST_ADD_FULL:
            begin
                if (out_free)
                begin
                    state_next = stq_pkg::ST_IDLE;
                end
            end
            stq_pkg::ST_MUL:
            begin
                state_next = stq_pkg::ST_SUM;
            end
            stq_pkg::ST_SUM:
            begin
                state_next = stq_pkg::ST_ADD_SCAN;
            end
            stq_pkg::ST_ADD_SCAN:
            begin
                if (pos_end)
                begin
                    state_next = stq_pkg::ST_ADD_ACK;
                end
            end
            stq_pkg::ST_ADD_ACK:
            begin
                if (out_free)
                begin
                    state_next = stq_pkg::ST_IDLE;
                end
            end
            stq_pkg::ST_TICK_SCAN:
            begin
                if (step && pos_end)
                begin
                    state_next = stq_pkg::ST_TICK_PUSH;
                end
            end
            stq_pkg::ST_TICK_PUSH:
            begin
                if (pos_end)
                begin
                    state_next = stq_pkg::ST_TICK_FILL;
                end
            end
            stq_pkg::ST_TICK_FILL:
            begin
                if (pos_end)
                begin
                    state_next = stq_pkg::ST_TICK_SUM;
                end
            end
            stq_pkg::ST_TICK_SUM:
            begin
                if (out_free)
                begin
                    state_next = stq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stq_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: ring movement, stack control and results.
    always_comb
    begin
        s_tready      = 1'b0;
        step          = 1'b0;
        ring_shift    = 1'b0;
        ring_in       = head;
        stk_ctl       = '0;
        emit          = 1'b0;
        emit_kind     = stq_pkg::KIND_ACK;
        emit_tag      = '0;
        emit_full     = 1'b0;
        emit_reload   = 1'b0;
        emit_interval = '0;
        unique case (state_reg)
            stq_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            stq_pkg::ST_ADD_FULL:
            begin
                emit      = 1'b1;
                emit_full = 1'b1;
            end
            stq_pkg::ST_MUL, stq_pkg::ST_SUM:
            begin
                emit = 1'b0;
            end
            stq_pkg::ST_ADD_SCAN:
            begin
                // The new timer drops into the first free slot as it passes the head.
                step       = 1'b1;
                ring_shift = 1'b1;
                if (pos_ext == count_reg)
                begin
                    ring_in = new_entry;
                end
            end
            stq_pkg::ST_ADD_ACK:
            begin
                emit        = 1'b1;
                emit_reload = earliest_reg;
                if (earliest_reg)
                begin
                    emit_interval = dl_reg - now_reg;
                end
            end
            stq_pkg::ST_TICK_SCAN:
            begin
                // An expired slot waits at the head until its result can be stored.
                step = !head_expired || out_free;
                ring_shift = step;
                ring_in = '{deadline: head.deadline, tag: head.tag, expired: head_expired};
                emit     = head_expired;
                emit_kind = stq_pkg::KIND_FIRED;
                emit_tag = head.tag;
            end
            stq_pkg::ST_TICK_PUSH:
            begin
                // Survivors at or above the new count must move down into holes.
                step         = 1'b1;
                ring_shift   = 1'b1;
                stk_ctl.push = in_tbl && (pos_ext >= surv_reg) && !head.expired;
            end
            stq_pkg::ST_TICK_FILL:
            begin
                // The lowest hole takes the highest-placed survivor, which sits on top.
                step       = 1'b1;
                ring_shift = 1'b1;
                if ((pos_ext < surv_reg) && head.expired)
                begin
                    stk_ctl.pop = 1'b1;
                    ring_in = '{deadline: stk_q[0].deadline, tag: stk_q[0].tag,
                                expired: 1'b0};
                end
            end
            stq_pkg::ST_TICK_SUM:
            begin
                emit          = 1'b1;
                emit_kind     = stq_pkg::KIND_SUMMARY;
                emit_reload   = 1'b1;
                emit_interval = any_reg ? best_reg : 64'(idle_w);
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Count update: an add bumps it once acknowledged, a tick sets it to the survivors.
    always_comb
    begin
        count_next = count_reg;
        if (state_reg == stq_pkg::ST_ADD_ACK && out_free)
        begin
            count_next = count_reg + stq_pkg::CNT_W'(1);
        end
        else if (state_reg == stq_pkg::ST_TICK_FILL && pos_end)
        begin
            count_next = surv_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stq_pkg::ST_IDLE;
            count_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (accept)
            begin
                pos_reg <= '0;
            end
            else if (step)
            begin
                pos_reg <= pos_end ? '0 : pos_reg + stq_pkg::IDX_W'(1);
            end
            if (emit && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and scan bookkeeping.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg      <= s_tdata[63:0];
            delay_reg    <= s_tdata[95:64];
            tag_reg      <= s_tdata[111:96];
            earliest_reg <= 1'b1;
            any_reg      <= 1'b0;
            best_reg     <= '1;
            surv_reg     <= '0;
        end
        if (state_reg == stq_pkg::ST_MUL)
        begin
            prod_reg <= prod_w;
        end
        if (state_reg == stq_pkg::ST_SUM)
        begin
            dl_reg <= dl_sum[64] ? '1 : dl_sum[63:0];
        end
        if (state_reg == stq_pkg::ST_ADD_SCAN && in_tbl && !(dl_reg < head.deadline))
        begin
            earliest_reg <= 1'b0;
        end
        if (state_reg == stq_pkg::ST_TICK_SCAN && step && in_tbl && !head_expired)
        begin
            any_reg  <= 1'b1;
            surv_reg <= surv_reg + stq_pkg::CNT_W'(1);
            if (head_dist < best_reg)
            begin
                best_reg <= head_dist;
            end
        end
        if (emit && out_free)
        begin
            out_kind_reg     <= emit_kind;
            out_tag_reg      <= emit_tag;
            out_full_reg     <= emit_full;
            out_reload_reg   <= emit_reload;
            out_interval_reg <= emit_interval;
            out_last_reg     <= emit_kind != stq_pkg::KIND_FIRED;
        end
    end

    // Ring of timer slots: slot 0 is at the head, the tail is fed by ring_in.
    for (genvar i = 0; i < N; i++)
    begin : g_ring
        stq_ring_cell u_cell (
            .clk       (clk),
            .shift     (ring_shift),
            .from_next ((i == N - 1) ? ring_in : ring_q[(i + 1) % N]),
            .q         (ring_q[i])
        );
    end

    // Relocation stack: cell 0 is the top.
    for (genvar k = 0; k < N; k++)
    begin : g_stack
        stq_stack_cell u_cell (
            .clk        (clk),
            .ctl        (stk_ctl),
            .from_above ((k == 0) ? head : stk_q[(k + N - 1) % N]),
            .from_below ((k == N - 1) ? zero_entry : stk_q[(k + 1) % N]),
            .q          (stk_q[k])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'b0, out_interval_reg, out_reload_reg, out_full_reg, out_tag_reg};

endmodule

// ===== hw/rtl/stq_checker.sv =====
// Port-level checks of the software timer queue, bound to the top level.
// Depends on stq_pkg and software_timer_queue.
module stq_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [87:0]  m_tdata,
    input logic [1:0]   m_tuser,
    input logic         m_tlast,
    input logic         m_tvalid,
    input logic         m_tready
);

    // A fired timer is never the final result of a request.
    a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == stq_pkg::KIND_FIRED |-> !m_tlast)
        else $error("fired result marked last");

    // Acknowledges and summaries always close their request.
    a_close_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == stq_pkg::KIND_ACK || m_tuser == stq_pkg::KIND_SUMMARY)
        |-> m_tlast)
        else $error("closing result not marked last");

    // A summary always asks for a reload.
    a_summary_reload: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == stq_pkg::KIND_SUMMARY |-> m_tdata[17])
        else $error("summary without reload");

    // Requests are handled one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // A stalled result stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result dropped");

endmodule

bind software_timer_queue stq_checker u_stq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
